>>> design/smx_pkg.sv
// Shared types and codes for the stack machine execute unit.
`default_nettype none

package smx_pkg;

    // Opcode codes
    localparam logic [4:0] OP_PUSH     = 5'd0;
    localparam logic [4:0] OP_ADD      = 5'd1;
    localparam logic [4:0] OP_SUB      = 5'd2;
    localparam logic [4:0] OP_MUL      = 5'd3;
    localparam logic [4:0] OP_DIV      = 5'd4;
    localparam logic [4:0] OP_MOD      = 5'd5;
    localparam logic [4:0] OP_STORE    = 5'd6;
    localparam logic [4:0] OP_RETRIEVE = 5'd7;
    localparam logic [4:0] OP_OUTC     = 5'd8;
    localparam logic [4:0] OP_OUTN     = 5'd9;
    localparam logic [4:0] OP_INC      = 5'd10;
    localparam logic [4:0] OP_INNUM    = 5'd11;
    localparam logic [4:0] OP_MARK     = 5'd12;
    localparam logic [4:0] OP_CALL     = 5'd13;
    localparam logic [4:0] OP_JMP      = 5'd14;
    localparam logic [4:0] OP_JZ       = 5'd15;
    localparam logic [4:0] OP_JN       = 5'd16;
    localparam logic [4:0] OP_END      = 5'd17;

    // Status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_UNDERFLOW   = 4'd1;
    localparam logic [3:0] ST_OVERFLOW    = 4'd2;
    localparam logic [3:0] ST_ZERO_DIV    = 4'd3;
    localparam logic [3:0] ST_BAD_ADDR    = 4'd4;
    localparam logic [3:0] ST_UNDEF_LABEL = 4'd5;
    localparam logic [3:0] ST_LABELS_FULL = 4'd6;
    localparam logic [3:0] ST_CALL_OVF    = 4'd7;
    localparam logic [3:0] ST_EMPTY_RET   = 4'd8;
    localparam logic [3:0] ST_STACK_FULL  = 4'd9;
    localparam logic [3:0] ST_HALTED      = 4'd10;

    // Output kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_NUM  = 2'd2;

    // Label table entry: key in the upper word, position below
    localparam int LAB_W = 48;

    typedef struct packed {
        logic [4:0]         opcode;
        logic signed [31:0] immediate;
        logic signed [31:0] label_id;
        logic [15:0]        next_position;
        logic               is_return;
    } item_t;

    typedef struct packed {
        logic [3:0]         status;
        logic [15:0]        new_position;
        logic [1:0]         out_kind;
        logic signed [31:0] out_value;
        logic               running;
    } result_t;

    typedef enum logic [2:0] {
        GRP_NOP,
        GRP_RET,
        GRP_PUSH,
        GRP_BIN,
        GRP_UN,
        GRP_MARK,
        GRP_FLOW,
        GRP_END
    } grp_t;

    typedef struct packed {
        grp_t  grp;
        item_t item;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_out_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RET_RD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_FLOW,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_MUL_CHK,
        S_DIV_WAIT,
        S_HEAP_RD,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> design/smx_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/smx_div.sv
// Iterative signed divider, one quotient bit per cycle, C truncation rules.
`default_nettype none

module smx_div
    import smx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic        active_reg, active_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_q_reg, neg_q_next;
    logic        neg_r_reg, neg_r_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // Shift in one dividend bit and trial subtract
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = 5'd0;
            rem_next    = 32'd0;
            quo_next    = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
            dvs_next    = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
            neg_q_next  = req.dividend[31] ^ req.divisor[31];
            neg_r_next  = req.dividend[31];
        end
        else if (active_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= 5'd0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // Apply signs to the magnitudes
    assign rsp.done      = done_reg;
    assign rsp.quotient  = neg_q_reg ? 32'd0 - quo_reg : quo_reg;
    assign rsp.remainder = neg_r_reg ? 32'd0 - rem_reg : rem_reg;

endmodule

`default_nettype wire

>>> design/smx_front.sv
// Front end: takes instruction transfers, classifies them, queues them.
`default_nettype none

module smx_front
    import smx_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    input  wire logic  clearing,
    input  wire logic  pop,
    output logic       busy,
    output q_out_t     q_out
);

    cmd_t       ent_reg [2];
    cmd_t       ent_next [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    grp_t       grp;

    // Classify the instruction
    always_comb
    begin
        if (item.is_return)
        begin
            grp = GRP_RET;
        end
        else if (item.opcode == OP_PUSH)
        begin
            grp = GRP_PUSH;
        end
        else if (item.opcode >= OP_ADD && item.opcode <= OP_STORE)
        begin
            grp = GRP_BIN;
        end
        else if (item.opcode >= OP_RETRIEVE && item.opcode <= OP_INNUM)
        begin
            grp = GRP_UN;
        end
        else if (item.opcode == OP_MARK)
        begin
            grp = GRP_MARK;
        end
        else if (item.opcode >= OP_CALL && item.opcode <= OP_JN)
        begin
            grp = GRP_FLOW;
        end
        else if (item.opcode == OP_END)
        begin
            grp = GRP_END;
        end
        else
        begin
            grp = GRP_NOP;
        end
    end

    assign busy = (cnt_reg == 2'd2) || clearing;
    assign push = start && !busy;

    // Advance the queue pointers
    always_comb
    begin
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            ent_next[wr_ptr_reg] = '{grp: grp, item: item};
            wr_ptr_next          = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.cmd   = ent_reg[rd_ptr_reg];

endmodule

`default_nettype wire

>>> design/smx_back.sv
// Back end: executes queued instructions against stacks, heap and label table.
`default_nettype none

module smx_back
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int HEAP_WORDS  = 1024,
    parameter int LABEL_SLOTS = 256,
    parameter int CALL_DEPTH  = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire q_out_t q_out,
    output logic        pop,
    output logic        clearing,
    output logic        done,
    output result_t     result
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int STW = $clog2(STACK_DEPTH + 1);
    localparam int HAW = $clog2(HEAP_WORDS);
    localparam int LAW = $clog2(LABEL_SLOTS);
    localparam int LCW = $clog2(LABEL_SLOTS + 1);
    localparam int RAW = $clog2(CALL_DEPTH);
    localparam int RCW = $clog2(CALL_DEPTH + 1);

    state_t        state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   b_reg, b_next;
    logic [63:0]   prod_reg, prod_next;
    logic [3:0]    status_reg, status_next;
    logic [15:0]   newp_reg, newp_next;
    logic [1:0]    kind_reg, kind_next;
    logic [31:0]   val_reg, val_next;
    logic [15:0]   target_reg, target_next;
    logic          found_reg, found_next;
    logic [STW-1:0] top_reg, top_next;
    logic [RCW-1:0] rtop_reg, rtop_next;
    logic [LCW-1:0] used_reg, used_next;
    logic [LCW-1:0] idx_reg, idx_next;
    logic [HAW-1:0] clr_reg, clr_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    // Memory ports
    logic             stk_we;
    logic [SAW-1:0]   stk_waddr, stk_raddr;
    logic [31:0]      stk_wdata, stk_rdata;
    logic             heap_we;
    logic [HAW-1:0]   heap_waddr, heap_raddr;
    logic [31:0]      heap_wdata, heap_rdata;
    logic             lab_we;
    logic [LAW-1:0]   lab_waddr, lab_raddr;
    logic [LAB_W-1:0] lab_wdata, lab_rdata;
    logic             ret_we;
    logic [RAW-1:0]   ret_waddr, ret_raddr;
    logic [15:0]      ret_wdata, ret_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Decision terms
    logic [STW-1:0] top_dec, top_dec2;
    logic [RCW-1:0] rtop_dec;
    logic           halted, ret_empty, stk_full, lt1, lt2;
    logic           labels_full, call_full, srch_end, key_hit, clr_last;
    logic [32:0]    sum;
    logic           add_ovf, mul_ovf, b_zero, b_neg1, a_addr_ok, b_addr_ok;
    logic           push_en;
    logic [31:0]    push_val;
    logic [4:0]     op;

    assign op          = cmd_reg.item.opcode;
    assign top_dec     = top_reg - STW'(1);
    assign top_dec2    = top_reg - STW'(2);
    assign rtop_dec    = rtop_reg - RCW'(1);
    assign halted      = !run_reg;
    assign ret_empty   = (rtop_reg == RCW'(0));
    assign stk_full    = (top_reg >= STW'(STACK_DEPTH));
    assign lt1         = (top_reg == STW'(0));
    assign lt2         = (top_reg < STW'(2));
    assign labels_full = (used_reg >= LCW'(LABEL_SLOTS));
    assign call_full   = (rtop_reg >= RCW'(CALL_DEPTH));
    assign srch_end    = (idx_reg >= used_reg);
    assign key_hit     = (lab_rdata[LAB_W-1:16] == cmd_reg.item.label_id);
    assign clr_last    = (clr_reg == HAW'(HEAP_WORDS - 1));
    assign sum         = {a_reg[31], a_reg} + {b_reg[31], b_reg};
    assign add_ovf     = (sum[32] != sum[31]);
    assign mul_ovf     = !((&prod_reg[63:31]) || !(|prod_reg[63:31]));
    assign b_zero      = (b_reg == 32'd0);
    assign b_neg1      = (b_reg == 32'hFFFF_FFFF);
    assign a_addr_ok   = (a_reg < 32'(HEAP_WORDS));
    assign b_addr_ok   = (b_reg < 32'(HEAP_WORDS));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_out.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (halted)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    case (cmd_reg.grp)
                        GRP_RET:  state_next = ret_empty ? S_DONE : S_RET_RD;
                        GRP_BIN:  state_next = lt2 ? S_DONE : S_RD_B;
                        GRP_UN:   state_next = lt1 ? S_DONE : S_RD_B;
                        GRP_MARK: state_next = S_SRCH_RD;
                        GRP_FLOW: state_next = S_SRCH_RD;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_RET_RD:   state_next = S_DONE;
            S_SRCH_RD:  state_next = srch_end ? S_FLOW : S_SRCH_CMP;
            S_SRCH_CMP: state_next = key_hit ? S_FLOW : S_SRCH_RD;
            S_FLOW:
            begin
                state_next = S_DONE;
                if (cmd_reg.grp == GRP_FLOW && found_reg && !lt1
                    && (op == OP_JZ || op == OP_JN))
                begin
                    state_next = S_RD_B;
                end
            end
            S_RD_B:     state_next = (cmd_reg.grp == GRP_BIN) ? S_RD_A : S_EXEC;
            S_RD_A:     state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op)
                    OP_MUL:
                    begin
                        state_next = S_MUL_CHK;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (!b_zero && !b_neg1)
                        begin
                            state_next = S_DIV_WAIT;
                        end
                    end
                    OP_RETRIEVE:
                    begin
                        if (b_addr_ok)
                        begin
                            state_next = S_HEAP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_MUL_CHK:  state_next = S_DONE;
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_HEAP_RD:  state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        cmd_next    = cmd_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        prod_next   = prod_reg;
        status_next = status_reg;
        newp_next   = newp_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        target_next = target_reg;
        found_next  = found_reg;
        top_next    = top_reg;
        rtop_next   = rtop_reg;
        used_next   = used_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;
        push_en     = 1'b0;
        push_val    = 32'd0;
        stk_raddr   = top_dec[SAW-1:0];
        heap_we     = 1'b0;
        heap_waddr  = b_reg[HAW-1:0];
        heap_wdata  = cmd_reg.item.immediate;
        heap_raddr  = b_reg[HAW-1:0];
        lab_we      = 1'b0;
        lab_waddr   = idx_reg[LAW-1:0];
        lab_wdata   = {cmd_reg.item.label_id, cmd_reg.item.next_position};
        lab_raddr   = idx_reg[LAW-1:0];
        ret_we      = 1'b0;
        ret_waddr   = rtop_reg[RAW-1:0];
        ret_wdata   = cmd_reg.item.next_position;
        ret_raddr   = rtop_dec[RAW-1:0];
        div_req     = '{start: 1'b0, dividend: a_reg, divisor: b_reg};

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the heap to zero
                heap_we    = 1'b1;
                heap_waddr = clr_reg;
                heap_wdata = 32'd0;
                clr_next   = clr_reg + HAW'(1);
            end
            S_IDLE:
            begin
                if (q_out.valid)
                begin
                    pop         = 1'b1;
                    cmd_next    = q_out.cmd;
                    status_next = ST_OK;
                    newp_next   = q_out.cmd.item.next_position;
                    kind_next   = KIND_NONE;
                    val_next    = 32'd0;
                    found_next  = 1'b0;
                    idx_next    = LCW'(0);
                end
            end
            S_DISPATCH:
            begin
                if (halted)
                begin
                    status_next = ST_HALTED;
                end
                else
                begin
                    case (cmd_reg.grp)
                        GRP_RET:
                        begin
                            if (ret_empty)
                            begin
                                status_next = ST_EMPTY_RET;
                            end
                            else
                            begin
                                rtop_next = rtop_dec;
                            end
                        end
                        GRP_PUSH:
                        begin
                            if (stk_full)
                            begin
                                status_next = ST_STACK_FULL;
                            end
                            else
                            begin
                                push_en  = 1'b1;
                                push_val = cmd_reg.item.immediate;
                            end
                        end
                        GRP_BIN:
                        begin
                            if (lt2)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                        end
                        GRP_UN:
                        begin
                            if (lt1)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                        end
                        GRP_END:
                        begin
                            run_next = 1'b0;
                        end
                        default:
                        begin
                            run_next = run_reg;
                        end
                    endcase
                end
            end
            S_RET_RD:
            begin
                newp_next = ret_rdata;
            end
            S_SRCH_CMP:
            begin
                if (key_hit)
                begin
                    found_next  = 1'b1;
                    target_next = lab_rdata[15:0];
                end
                else
                begin
                    idx_next = idx_reg + LCW'(1);
                end
            end
            S_FLOW:
            begin
                if (cmd_reg.grp == GRP_MARK)
                begin
                    // Update an existing label or append a new one
                    if (found_reg)
                    begin
                        lab_we = 1'b1;
                    end
                    else if (labels_full)
                    begin
                        status_next = ST_LABELS_FULL;
                    end
                    else
                    begin
                        lab_we    = 1'b1;
                        lab_waddr = used_reg[LAW-1:0];
                        used_next = used_reg + LCW'(1);
                    end
                end
                else if (!found_reg)
                begin
                    status_next = ST_UNDEF_LABEL;
                end
                else
                begin
                    case (op)
                        OP_CALL:
                        begin
                            if (call_full)
                            begin
                                status_next = ST_CALL_OVF;
                            end
                            else
                            begin
                                ret_we    = 1'b1;
                                rtop_next = rtop_reg + RCW'(1);
                                newp_next = target_reg;
                            end
                        end
                        OP_JMP:
                        begin
                            newp_next = target_reg;
                        end
                        default:
                        begin
                            if (lt1)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                        end
                    endcase
                end
            end
            S_RD_B:
            begin
                // Pop the top word; fetch the next one for two-operand ops
                b_next    = stk_rdata;
                top_next  = top_dec;
                stk_raddr = top_dec2[SAW-1:0];
            end
            S_RD_A:
            begin
                a_next   = stk_rdata;
                top_next = top_dec;
            end
            S_EXEC:
            begin
                case (op)
                    OP_ADD:
                    begin
                        if (add_ovf)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            push_en  = 1'b1;
                            push_val = sum[31:0];
                        end
                    end
                    OP_SUB:
                    begin
                        push_en  = 1'b1;
                        push_val = a_reg - b_reg;
                    end
                    OP_MUL:
                    begin
                        prod_next = 64'($signed(a_reg) * $signed(b_reg));
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (b_zero)
                        begin
                            status_next = ST_ZERO_DIV;
                        end
                        else if (b_neg1)
                        begin
                            push_en  = 1'b1;
                            push_val = (op == OP_DIV) ? 32'd0 - a_reg : 32'd0;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                        end
                    end
                    OP_STORE:
                    begin
                        if (a_addr_ok)
                        begin
                            heap_we    = 1'b1;
                            heap_waddr = a_reg[HAW-1:0];
                            heap_wdata = b_reg;
                        end
                        else
                        begin
                            status_next = ST_BAD_ADDR;
                        end
                    end
                    OP_RETRIEVE:
                    begin
                        if (!b_addr_ok)
                        begin
                            status_next = ST_BAD_ADDR;
                        end
                    end
                    OP_OUTC:
                    begin
                        kind_next = KIND_CHAR;
                        val_next  = b_reg;
                    end
                    OP_OUTN:
                    begin
                        kind_next = KIND_NUM;
                        val_next  = b_reg;
                    end
                    OP_INC, OP_INNUM:
                    begin
                        if (b_addr_ok)
                        begin
                            heap_we = 1'b1;
                        end
                        else
                        begin
                            status_next = ST_BAD_ADDR;
                        end
                    end
                    OP_JZ:
                    begin
                        if (b_zero)
                        begin
                            newp_next = target_reg;
                        end
                    end
                    OP_JN:
                    begin
                        if (b_reg[31])
                        begin
                            newp_next = target_reg;
                        end
                    end
                    default:
                    begin
                        push_en = 1'b0;
                    end
                endcase
            end
            S_MUL_CHK:
            begin
                if (mul_ovf)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    push_en  = 1'b1;
                    push_val = prod_reg[31:0];
                end
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    push_en  = 1'b1;
                    push_val = (op == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
                end
            end
            S_HEAP_RD:
            begin
                push_en  = 1'b1;
                push_val = heap_rdata;
            end
            S_DONE:
            begin
                // Drop the run flag on any error and present the result
                run_next    = run_reg && (status_reg == ST_OK);
                done_next   = 1'b1;
                result_next = '{status: status_reg, new_position: newp_reg,
                                out_kind: kind_reg, out_value: val_reg,
                                running: run_reg && (status_reg == ST_OK)};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        if (push_en)
        begin
            top_next = top_reg + STW'(1);
        end
    end

    assign stk_we    = push_en;
    assign stk_waddr = top_reg[SAW-1:0];
    assign stk_wdata = push_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            top_reg   <= '0;
            rtop_reg  <= '0;
            used_reg  <= '0;
            clr_reg   <= '0;
            run_reg   <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            rtop_reg  <= rtop_next;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        prod_reg   <= prod_next;
        status_reg <= status_next;
        newp_reg   <= newp_next;
        kind_reg   <= kind_next;
        val_reg    <= val_next;
        target_reg <= target_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    assign clearing = (state_reg == S_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

    smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    smx_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    smx_ram #(.WIDTH(LAB_W), .DEPTH(LABEL_SLOTS)) u_labels (
        .clk   (clk),
        .we    (lab_we),
        .waddr (lab_waddr),
        .wdata (lab_wdata),
        .raddr (lab_raddr),
        .rdata (lab_rdata)
    );

    smx_ram #(.WIDTH(16), .DEPTH(CALL_DEPTH)) u_returns (
        .clk   (clk),
        .we    (ret_we),
        .waddr (ret_waddr),
        .wdata (ret_wdata),
        .raddr (ret_raddr),
        .rdata (ret_rdata)
    );

    smx_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire

>>> design/stack_machine_execute_unit.sv
// Div/mod wait on an iterative divider, one quotient bit a cycle.
// Label instructions search the label table entry by entry, a read then a compare (one table read port).
// Throughput: one instruction at a time in the back end; a 2-entry queue holds new transfers.
// Reset: stacks and labels empty, run flag set; the heap is then swept to zero with busy
// high. The result strobe lasts one cycle and cannot be held off.
`default_nettype none

module stack_machine_execute_unit
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int HEAP_WORDS  = 1024,
    parameter int LABEL_SLOTS = 256,
    parameter int CALL_DEPTH  = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output logic       done,
    output result_t    result
);

    q_out_t q_out;
    logic   pop;
    logic   clearing;

    smx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .clearing (clearing),
        .pop      (pop),
        .busy     (busy),
        .q_out    (q_out)
    );

    smx_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .HEAP_WORDS  (HEAP_WORDS),
        .LABEL_SLOTS (LABEL_SLOTS),
        .CALL_DEPTH  (CALL_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_out    (q_out),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

>>> tb/stack_machine_execute_unit_checker.sv
// Checker for the stack machine execute unit: predicts each result and compares it.
module stack_machine_execute_unit_checker
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 256,
    parameter int HEAP_WORDS  = 1024,
    parameter int LABEL_SLOTS = 256,
    parameter int CALL_DEPTH  = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire item_t item,
    input  wire logic done,
    input  wire result_t result,
    output int        mismatches,
    output int        in_flight,
    output int        results_checked
);

    // Shadow machine state
    logic [31:0] stack_words [STACK_DEPTH];
    int          stack_count;
    logic [31:0] heap_words [HEAP_WORDS];
    logic [31:0] label_keys [LABEL_SLOTS];
    logic [15:0] label_pos [LABEL_SLOTS];
    int          label_total;
    logic [15:0] return_pos [CALL_DEPTH];
    int          return_count;
    logic        run_flag;

    result_t     pending_results [$];
    int          error_count;

    initial
    begin
        for (int i = 0; i < HEAP_WORDS; i++)
            heap_words[i] = '0;
        stack_count  = 0;
        label_total  = 0;
        return_count = 0;
        run_flag     = 1'b1;
        error_count  = 0;
        mismatches   = 0;
        in_flight    = 0;
        results_checked = 0;
    end

    function automatic int find_label(logic [31:0] key);
        for (int i = 0; i < label_total; i++)
            if (label_keys[i] == key)
                return i;
        return -1;
    endfunction

    function automatic logic [31:0] pop_word();
        stack_count--;
        return stack_words[stack_count];
    endfunction

    function automatic void push_word(logic [31:0] v);
        stack_words[stack_count] = v;
        stack_count++;
    endfunction

    function automatic bit heap_addr_ok(longint a);
        return a >= 0 && a < HEAP_WORDS;
    endfunction

    // Execute one instruction on the shadow state and build its result
    task automatic execute_instruction(input item_t it, output result_t r);
        logic [31:0] ua, ub, w;
        longint      a, b, p;
        int          slot;
        r = '0;
        r.status       = ST_OK;
        r.new_position = it.next_position;
        r.out_kind     = KIND_NONE;
        if (!run_flag)
            r.status = ST_HALTED;
        else if (it.is_return)
        begin
            if (return_count == 0)
                r.status = ST_EMPTY_RET;
            else
            begin
                return_count--;
                r.new_position = return_pos[return_count];
            end
        end
        else
        begin
            case (it.opcode)
                OP_PUSH:
                    if (stack_count >= STACK_DEPTH)
                        r.status = ST_STACK_FULL;
                    else
                        push_word(it.immediate);
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_STORE:
                    if (stack_count < 2)
                        r.status = ST_UNDERFLOW;
                    else
                    begin
                        ub = pop_word();
                        ua = pop_word();
                        a  = longint'($signed(ua));
                        b  = longint'($signed(ub));
                        case (it.opcode)
                            OP_ADD, OP_MUL:
                            begin
                                p = (it.opcode == OP_ADD) ? a + b : a * b;
                                if (p > 64'sd2147483647 || p < -64'sd2147483648)
                                    r.status = ST_OVERFLOW;
                                else
                                    push_word(p[31:0]);
                            end
                            OP_SUB:
                                push_word(ua - ub);
                            OP_DIV, OP_MOD:
                                if (b == 0)
                                    r.status = ST_ZERO_DIV;
                                else if (b == -1)
                                    push_word(it.opcode == OP_DIV ? 32'd0 - ua : 32'd0);
                                else
                                begin
                                    p = (it.opcode == OP_DIV) ? a / b : a % b;
                                    push_word(p[31:0]);
                                end
                            default:
                                if (!heap_addr_ok(a))
                                    r.status = ST_BAD_ADDR;
                                else
                                    heap_words[a] = ub;
                        endcase
                    end
                OP_RETRIEVE, OP_OUTC, OP_OUTN, OP_INC, OP_INNUM:
                    if (stack_count < 1)
                        r.status = ST_UNDERFLOW;
                    else
                    begin
                        w = pop_word();
                        a = longint'($signed(w));
                        if (it.opcode == OP_OUTC || it.opcode == OP_OUTN)
                        begin
                            r.out_kind  = (it.opcode == OP_OUTC) ? KIND_CHAR : KIND_NUM;
                            r.out_value = w;
                        end
                        else if (!heap_addr_ok(a))
                            r.status = ST_BAD_ADDR;
                        else if (it.opcode == OP_RETRIEVE)
                            push_word(heap_words[a]);
                        else
                            heap_words[a] = it.immediate;
                    end
                OP_MARK:
                begin
                    slot = find_label(it.label_id);
                    if (slot >= 0)
                        label_pos[slot] = it.next_position;
                    else if (label_total >= LABEL_SLOTS)
                        r.status = ST_LABELS_FULL;
                    else
                    begin
                        label_keys[label_total] = it.label_id;
                        label_pos[label_total]  = it.next_position;
                        label_total++;
                    end
                end
                OP_CALL, OP_JMP, OP_JZ, OP_JN:
                begin
                    slot = find_label(it.label_id);
                    if (slot < 0)
                        r.status = ST_UNDEF_LABEL;
                    else if (it.opcode == OP_CALL)
                    begin
                        if (return_count >= CALL_DEPTH)
                            r.status = ST_CALL_OVF;
                        else
                        begin
                            return_pos[return_count] = it.next_position;
                            return_count++;
                            r.new_position = label_pos[slot];
                        end
                    end
                    else if (it.opcode == OP_JMP)
                        r.new_position = label_pos[slot];
                    else if (stack_count < 1)
                        r.status = ST_UNDERFLOW;
                    else
                    begin
                        w = pop_word();
                        if ((it.opcode == OP_JZ && w == 0) || (it.opcode == OP_JN && w[31]))
                            r.new_position = label_pos[slot];
                    end
                end
                OP_END:
                    run_flag = 1'b0;
                default:
                    ;
            endcase
        end
        if (r.status != ST_OK)
            run_flag = 1'b0;
        r.running = run_flag;
    endtask

    task automatic report_field(string field, longint exp_v, longint act_v);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
        error_count++;
    endtask

    // Compare each result transfer, then predict each accepted instruction
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h", $time, result);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    got  = result;
                    if (got.status !== want.status)
                        report_field("status", want.status, got.status);
                    if (got.new_position !== want.new_position)
                        report_field("new_position", want.new_position, got.new_position);
                    if (got.out_kind !== want.out_kind)
                        report_field("out_kind", want.out_kind, got.out_kind);
                    if (got.out_value !== want.out_value)
                        report_field("out_value", want.out_value, got.out_value);
                    if (got.running !== want.running)
                        report_field("running", want.running, got.running);
                    results_checked <= results_checked + 1;
                end
            end
            if (start && !busy)
            begin
                execute_instruction(item, want);
                pending_results.push_back(want);
            end
        end
        in_flight  <= pending_results.size();
        mismatches <= error_count;
    end

endmodule

>>> tb/stack_machine_execute_unit_test.sv
// Testbench top for the stack machine execute unit: stimulus, watchdog and verdict.
module stack_machine_execute_unit_test;
    import smx_pkg::*;

    localparam int STACK_DEPTH = 256;
    localparam int HEAP_WORDS  = 1024;
    localparam int LABEL_SLOTS = 256;
    localparam int CALL_DEPTH  = 64;
    localparam int BODY_ITEMS  = 1200;
    localparam int IDLE_LIMIT  = 20000;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;
    int      mismatches;
    int      in_flight;
    int      results_checked;

    // Sender-side view of the machine, kept only to build legal sequences
    int          depth;
    int          call_depth;
    logic [31:0] defined_keys [$];
    int          burst_left;
    int          sent;
    int          idle_cycles;
    string       ending;

    stack_machine_execute_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    stack_machine_execute_unit_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .item            (item),
        .done            (done),
        .result          (result),
        .mismatches      (mismatches),
        .in_flight       (in_flight),
        .results_checked (results_checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Abort when no transfer happens for too long
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("stack_machine_execute_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic bit key_known(logic [31:0] key);
        foreach (defined_keys[i])
            if (defined_keys[i] == key)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] k;
        k = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
        while (key_known(k))
            k = $urandom;
        return k;
    endfunction

    function automatic logic [31:0] some_key();
        return defined_keys[$urandom_range(0, defined_keys.size() - 1)];
    endfunction

    function automatic logic [31:0] heap_addr();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'(HEAP_WORDS - 1);
            default: return 32'($urandom_range(0, HEAP_WORDS - 1));
        endcase
    endfunction

    // Drive one instruction and hold it until the transfer; gaps fall between bursts
    task automatic send(input logic [4:0] op, input logic [31:0] imm,
                        input logic [31:0] lab, input logic ret);
        item_t it;
        int    gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        it.opcode        = op;
        it.immediate     = imm;
        it.label_id      = lab;
        it.next_position = 16'($urandom_range(0, 65535));
        it.is_return     = ret;
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic push(input logic [31:0] v);
        send(OP_PUSH, v, $urandom, 1'b0);
        depth++;
    endtask

    task automatic binary(input logic [4:0] op, input logic [31:0] a, input logic [31:0] b);
        push(a);
        push(b);
        send(op, $urandom, $urandom, 1'b0);
        depth -= (op == OP_STORE) ? 2 : 1;
    endtask

    task automatic mark(input logic [31:0] key);
        send(OP_MARK, $urandom, key, 1'b0);
        if (!key_known(key))
            defined_keys.push_back(key);
    endtask

    task automatic call(input logic [31:0] key);
        send(OP_CALL, $urandom, key, 1'b0);
        call_depth++;
    endtask

    task automatic ret();
        send(5'($urandom_range(0, 31)), $urandom, $urandom, 1'b1);
        call_depth--;
    endtask

    task automatic pop_out(input logic [4:0] op);
        send(op, $urandom, $urandom, 1'b0);
        depth--;
    endtask

    // Hold the sender until every result is back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    // One random well-formed step of a program
    task automatic random_step();
        logic [31:0] a, b;
        longint      p;
        logic [4:0]  op;
        if (depth > 150)
        begin
            pop_out(OP_OUTN);
            return;
        end
        if (defined_keys.size() == 0)
        begin
            mark(fresh_key());
            return;
        end
        case ($urandom_range(0, 15))
            0, 1, 2:
            begin
                op = 5'($urandom_range(OP_ADD, OP_MUL));
                a  = rand_word();
                b  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 70000)) : rand_word();
                p  = (op == OP_MUL) ? longint'($signed(a)) * longint'($signed(b))
                                    : longint'($signed(a)) + longint'($signed(b));
                // keep add and multiply in range; subtract may wrap freely
                if (op != OP_SUB && (p > 64'sd2147483647 || p < -64'sd2147483648))
                    b = (op == OP_ADD) ? 32'd0 : 32'd1;
                binary(op, a, b);
            end
            3:
            begin
                a = ($urandom_range(0, 7) == 0) ? 32'h8000_0000 : rand_word();
                b = ($urandom_range(0, 7) == 0) ? 32'hffff_ffff : rand_word();
                if (b == 0)
                    b = 32'd7;
                binary($urandom_range(0, 1) ? OP_DIV : OP_MOD, a, b);
            end
            4:
                binary(OP_STORE, heap_addr(), rand_word());
            5:
            begin
                push(heap_addr());
                send(OP_RETRIEVE, $urandom, $urandom, 1'b0);
            end
            6:
            begin
                if (depth == 0 || $urandom_range(0, 1) == 0)
                    push(rand_word());
                pop_out($urandom_range(0, 1) ? OP_OUTC : OP_OUTN);
            end
            7:
            begin
                push(heap_addr());
                op = $urandom_range(0, 1) ? OP_INC : OP_INNUM;
                send(op, ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : rand_word(),
                     $urandom, 1'b0);
                depth--;
            end
            8:
                mark((defined_keys.size() < 40 && $urandom_range(0, 1)) ? fresh_key()
                                                                        : some_key());
            9:
                if (call_depth < CALL_DEPTH)
                    call(some_key());
            10:
                if (call_depth > 0)
                    ret();
            11:
                send(OP_JMP, $urandom, some_key(), 1'b0);
            12:
            begin
                case ($urandom_range(0, 3))
                    0: push(32'd0);
                    1: push(32'hffff_ffff);
                    default: push(rand_word());
                endcase
                send($urandom_range(0, 1) ? OP_JZ : OP_JN, $urandom, some_key(), 1'b0);
                depth--;
            end
            13:
                send(5'($urandom_range(OP_END + 1, 31)), $urandom, $urandom, 1'b0);
            14:
                push(rand_word());
            default:
                if (depth > 0)
                    pop_out(OP_OUTN);
        endcase
    endtask

    // Finish the program on one terminal case, chosen by the seed
    task automatic terminate();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0:
            begin
                ending = "underflow";
                while (depth > 0)
                    pop_out(OP_OUTN);
                send($urandom_range(0, 1) ? OP_ADD : OP_RETRIEVE, $urandom, $urandom, 1'b0);
            end
            1:
            begin
                ending = "overflow";
                if ($urandom_range(0, 1))
                    binary(OP_ADD, 32'h7fff_ffff, 32'd1);
                else
                    binary(OP_MUL, 32'h8000_0000, 32'hffff_ffff);
            end
            2:
            begin
                ending = "zero divisor";
                binary($urandom_range(0, 1) ? OP_DIV : OP_MOD, rand_word(), 32'd0);
            end
            3:
            begin
                ending = "bad heap address";
                push($urandom_range(0, 1) ? 32'hffff_ffff : 32'(HEAP_WORDS));
                send($urandom_range(0, 1) ? OP_RETRIEVE : OP_INNUM, $urandom, $urandom, 1'b0);
            end
            4:
            begin
                ending = "undefined label";
                send(5'($urandom_range(OP_CALL, OP_JN)), $urandom, fresh_key(), 1'b0);
            end
            5:
            begin
                ending = "label table full";
                while (defined_keys.size() < LABEL_SLOTS)
                    mark(fresh_key());
                mark(fresh_key());
            end
            6:
            begin
                ending = "call overflow";
                if (defined_keys.size() == 0)
                    mark(fresh_key());
                k = some_key();
                while (call_depth <= CALL_DEPTH)
                    call(k);
            end
            7:
            begin
                ending = "empty return";
                while (call_depth >= 0)
                    ret();
            end
            8:
            begin
                ending = "stack full";
                while (depth <= STACK_DEPTH)
                    push(rand_word());
            end
            default:
            begin
                ending = "end instruction";
                send(OP_END, $urandom, $urandom, 1'b0);
            end
        endcase
        // everything after this point must come back halted
        repeat (6)
            send(5'($urandom_range(0, 31)), $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        depth      = 0;
        call_depth = 0;
        burst_left = 0;
        sent       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: arithmetic extremes, heap ends, output, input, flow control
        binary(OP_SUB, 32'h8000_0000, 32'h7fff_ffff);
        binary(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        binary(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
        binary(OP_MOD, 32'hffff_fff9, 32'd2);
        binary(OP_MUL, 32'h7fff_ffff, 32'd1);
        binary(OP_STORE, 32'(HEAP_WORDS - 1), 32'h8000_0000);
        push(32'(HEAP_WORDS - 1));
        send(OP_RETRIEVE, 0, 0, 1'b0);
        push(32'd5);
        send(OP_RETRIEVE, 0, 0, 1'b0);
        pop_out(OP_OUTC);
        pop_out(OP_OUTN);
        push(32'd0);
        send(OP_INC, 32'hffff_ffff, 0, 1'b0);
        depth--;
        mark(32'h8000_0000);
        mark(32'h8000_0000);
        call(32'h8000_0000);
        ret();
        send(OP_JMP, 0, 32'h8000_0000, 1'b0);
        push(32'h8000_0000);
        send(OP_JN, 0, 32'h8000_0000, 1'b0);
        depth--;
        send(5'd31, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        drain();

        // Random well-formed programs, with full drains now and then
        while (sent < BODY_ITEMS)
        begin
            random_step();
            if ($urandom_range(0, 199) == 0)
                drain();
        end
        drain();
        terminate();
        drain();
        repeat (60) @(posedge clk);

        $display("Ran %0d instructions, %0d results checked, %0d labels defined.",
                 sent, results_checked, defined_keys.size());
        $display("The program ended on: %s, followed by halted instructions.", ending);
        if (mismatches == 0)
            $display("stack_machine_execute_unit regression: pass");
        else
            $display("stack_machine_execute_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
design/smx_pkg.sv
design/smx_ram.sv
design/smx_div.sv
design/smx_front.sv
design/smx_back.sv
design/stack_machine_execute_unit.sv
tb/stack_machine_execute_unit_checker.sv
tb/stack_machine_execute_unit_test.sv
